// ----- hw/rtl/mbet_pkg.sv -----
// Package for the escape-time scan line block.
// Holds the widths, register indexes, reset values, command and status structs
// and the controller state type. It depends on nothing else.
package mbet_pkg;

    localparam int FRAC_BITS      = 28;
    localparam int MAX_ITER_LIMIT = 4096;
    localparam int MAX_LINE_WIDTH = 4096;

    localparam int COORD_W   = 32;
    localparam int CNT_W     = 13;
    localparam int COL_W     = 12;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int SPAN_W   = COORD_W + 1;
    localparam int PROD_W   = SPAN_W + COL_W + 1;
    localparam int CX_W     = PROD_W + 1;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam int MAG_W = FRAC_BITS + 2;
    localparam int SQ_W  = MAG_W + 2;
    localparam int PM_W  = MAG_W + 3;
    localparam int NX_W  = CX_W + 1;
    localparam int NY_W  = PM_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERS  = 3'd3;

    localparam logic [COORD_W-1:0] RST_X_LEFT     = 32'hE000_0000;
    localparam logic [COORD_W-1:0] RST_X_RIGHT    = 32'h1000_0000;
    localparam logic [CNT_W-1:0]   RST_LINE_WIDTH = 13'd512;
    localparam logic [CNT_W-1:0]   RST_MAX_ITERS  = 13'd30;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic set_cx;
        logic step;
        logic square;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic finish;
        logic out_free;
    } t_stat;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_DSTART = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_ITER   = 7'b0010000,
        S_SQR    = 7'b0100000,
        S_HOLD   = 7'b1000000
    } t_state;

endpackage

// ----- hw/rtl/mbet_div.sv -----
// Restoring divider, one quotient bit per cycle, for the column offset.
// Uses widths from mbet_pkg.
module mbet_div
    import mbet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic [PROD_W-1:0] o_quotient,
    output logic              o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dvs;
    logic [PROD_W-1:0]    r_quo;

    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;
    logic [CNT_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// ----- hw/rtl/mbet_dpath.sv -----
// Datapath: configuration registers, column scaling, the iteration registers
// and the output register. Uses mbet_pkg and instantiates mbet_div.
module mbet_dpath
    import mbet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [COORD_W-1:0] i_row_im,
    input  logic [COL_W-1:0]   i_column,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CNT_W-1:0]   o_escape_count,
    output logic [COL_W-1:0]   o_column_out
);

    localparam logic signed [NX_W-1:0] THREE = NX_W'(3) <<< FRAC_BITS;
    localparam logic [SQ_W:0]          FOUR  = (SQ_W + 1)'(1) << (FRAC_BITS + 2);

    function automatic logic signed [COORD_W-1:0] sat3(input logic signed [NX_W-1:0] v);
        logic signed [NX_W-1:0] r;
        r = v;
        if (v > THREE) begin
            r = THREE;
        end else if (v < -THREE) begin
            r = -THREE;
        end
        return r[COORD_W-1:0];
    endfunction

    logic [COORD_W-1:0] r_x_left;
    logic [COORD_W-1:0] r_x_right;
    logic [CNT_W-1:0]   r_line_width;
    logic [CNT_W-1:0]   r_max_iters;

    logic signed [COORD_W-1:0] r_cy;
    logic [COL_W-1:0]          r_col;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CX_W-1:0]    r_cx;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [SQ_W-1:0]           r_x2;
    logic [SQ_W-1:0]           r_y2;
    logic [PM_W-1:0]           r_pm;
    logic                      r_sxy;
    logic [CNT_W-1:0]          r_n;

    logic             r_out_valid;
    logic [CNT_W-1:0] r_escape;
    logic [COL_W-1:0] r_col_out;

    logic [CNT_W-1:0]          w_lw;
    logic [CNT_W-1:0]          w_lim;
    logic signed [SPAN_W-1:0]  w_span;
    logic signed [PROD_W-1:0]  w_span_x;
    logic signed [PROD_W-1:0]  w_col_x;
    logic signed [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]         w_prod_mag;
    logic [PROD_W-1:0]         w_quo;
    logic                      w_div_done;
    logic signed [CX_W-1:0]    w_quo_s;
    logic signed [CX_W-1:0]    w_cx;
    logic [COORD_W-1:0]        w_ax_full;
    logic [COORD_W-1:0]        w_ay_full;
    logic [MAG_W-1:0]          w_ax;
    logic [MAG_W-1:0]          w_ay;
    logic [2*MAG_W-1:0]        w_xx;
    logic [2*MAG_W-1:0]        w_yy;
    logic [2*MAG_W-1:0]        w_xy;
    logic signed [PM_W:0]      w_p;
    logic signed [NX_W-1:0]    w_nx_sum;
    logic signed [NY_W-1:0]    w_ny_sum;
    logic [SQ_W:0]             w_mag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_left     <= RST_X_LEFT;
            r_x_right    <= RST_X_RIGHT;
            r_line_width <= RST_LINE_WIDTH;
            r_max_iters  <= RST_MAX_ITERS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_LEFT:     r_x_left     <= i_cfg_data[COORD_W-1:0];
                CFG_X_RIGHT:    r_x_right    <= i_cfg_data[COORD_W-1:0];
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_ITERS:  r_max_iters  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_lw = r_line_width;
        if (r_line_width == '0) begin
            w_lw = CNT_W'(1);
        end else if (r_line_width > CNT_W'(MAX_LINE_WIDTH)) begin
            w_lw = CNT_W'(MAX_LINE_WIDTH);
        end
        w_lim = r_max_iters;
        if (r_max_iters > CNT_W'(MAX_ITER_LIMIT)) begin
            w_lim = CNT_W'(MAX_ITER_LIMIT);
        end
    end

    assign w_span     = SPAN_W'($signed(r_x_right)) - SPAN_W'($signed(r_x_left));
    assign w_span_x   = PROD_W'(w_span);
    assign w_col_x    = $signed({{(PROD_W - COL_W){1'b0}}, r_col});
    assign w_prod     = w_span_x * w_col_x;
    assign w_prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    mbet_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_prod_mag),
        .i_divisor  (w_lw),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign w_quo_s = r_prod[PROD_W-1] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_cx    = CX_W'($signed(r_x_left)) + w_quo_s;

    assign w_ax_full = r_x[COORD_W-1] ? COORD_W'(-r_x) : COORD_W'(r_x);
    assign w_ay_full = r_y[COORD_W-1] ? COORD_W'(-r_y) : COORD_W'(r_y);
    assign w_ax      = w_ax_full[MAG_W-1:0];
    assign w_ay      = w_ay_full[MAG_W-1:0];
    assign w_xx      = w_ax * w_ax;
    assign w_yy      = w_ay * w_ay;
    assign w_xy      = w_ax * w_ay;

    assign w_p      = r_sxy ? -$signed({1'b0, r_pm}) : $signed({1'b0, r_pm});
    assign w_ny_sum = NY_W'(w_p) + NY_W'(r_cy);
    assign w_nx_sum = NX_W'($signed({1'b0, r_x2})) - NX_W'($signed({1'b0, r_y2}))
                    + NX_W'(r_cx);
    assign w_mag2   = {1'b0, r_x2} + {1'b0, r_y2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.set_cx) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.step) begin
            r_x <= sat3(w_nx_sum);
            r_y <= sat3(NX_W'(w_ny_sum));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cy  <= $signed(i_row_im);
            r_col <= i_column;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.set_cx) begin
            r_cx  <= w_cx;
            r_x2  <= '0;
            r_y2  <= '0;
            r_pm  <= '0;
            r_sxy <= 1'b0;
            r_n   <= '0;
        end else if (i_cmd.step) begin
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.square) begin
            r_x2  <= w_xx[2*MAG_W-1:FRAC_BITS];
            r_y2  <= w_yy[2*MAG_W-1:FRAC_BITS];
            r_pm  <= w_xy[2*MAG_W-1:FRAC_BITS-1];
            r_sxy <= r_x[COORD_W-1] ^ r_y[COORD_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_escape  <= r_n;
            r_col_out <= r_col;
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.finish   = (r_n >= w_lim) || (w_mag2 > FOUR);
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_escape_count = r_escape;
    assign o_column_out   = r_col_out;

    a_step_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_n < w_lim))
        else $error("iteration step issued at the cap");

    a_x_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NX_W'(r_x) <= THREE) && (NX_W'(r_x) >= -THREE)
        && (NX_W'(r_y) <= THREE) && (NX_W'(r_y) >= -THREE))
        else $error("iterate left the saturation range");

endmodule

// ----- hw/rtl/mbet_ctrl.sv -----
// Controller state machine: sequences load, scaling, division and the
// two-phase iteration, then hands the result to the output register. Uses mbet_pkg.
module mbet_ctrl
    import mbet_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.set_cx = 1'b1;
                    n_state      = S_ITER;
                end
            end
            S_ITER: begin
                if (i_stat.finish) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_ITER;
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result written over an unaccepted result");

endmodule

// ----- hw/rtl/mandelbrot_escape_time_line.sv -----
// Escape-time evaluator for one scan line pixel per request.
// After acceptance a request is loaded, its column is scaled and divided by the line
// width, and it is iterated in step/square phases until the result is presented.
// Only one request is in work at a time; a result may wait in the output
// register while the next request is taken. Synchronous active-low reset restores
// the register defaults and empties the block; no clearing pass follows.
module mandelbrot_escape_time_line
    import mbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COORD_W-1:0]   i_row_im,
    input  logic [COL_W-1:0]     i_column,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CNT_W-1:0]     o_escape_count,
    output logic [COL_W-1:0]     o_column_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    mbet_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mbet_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_row_im       (i_row_im),
        .i_column       (i_column),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_escape_count (o_escape_count),
        .o_column_out   (o_column_out)
    );

endmodule
